// ===== hw/rtl/kst_pkg.sv =====
// Shared types, register indexes and the tone repeat table of the keypad scanner.
`default_nettype none

package kst_pkg;

  localparam int unsigned RowW   = 4;
  localparam int unsigned ColW   = 4;
  localparam int unsigned KeyW   = 4;
  localparam int unsigned TimerW = 8;
  localparam int unsigned SettleW = 4;
  localparam int unsigned RepW   = 8;
  localparam int unsigned HalfW  = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSettle   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGap      = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgToneEn   = 2'd3;

  typedef struct packed {
    logic [ColW-1:0] column_drive;
    logic            buzzer_level;
    logic            key_strobe;
    logic [KeyW-1:0] key_code;
    logic            busy_res;
  } result_t;

  // Number of full wave periods played for each key.
  function automatic logic [RepW-1:0] repeat_count(input logic [KeyW-1:0] key);
    logic [RepW-1:0] cnt;
    case (key)
      4'd0:    cnt = 8'd250;
      4'd1:    cnt = 8'd125;
      4'd2:    cnt = 8'd83;
      4'd3:    cnt = 8'd63;
      4'd4:    cnt = 8'd50;
      4'd5:    cnt = 8'd42;
      4'd6:    cnt = 8'd38;
      4'd7:    cnt = 8'd31;
      4'd8:    cnt = 8'd28;
      4'd9:    cnt = 8'd25;
      4'd10:   cnt = 8'd23;
      4'd11:   cnt = 8'd21;
      4'd12:   cnt = 8'd25;
      4'd13:   cnt = 8'd22;
      4'd14:   cnt = 8'd19;
      default: cnt = 8'd16;
    endcase
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kst_skid.sv =====
// Two-entry output stage that decouples result beats from the downstream stall.
`default_nettype none

module kst_skid (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire kst_pkg::result_t in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output kst_pkg::result_t     out_data_o,
  input  wire logic            out_stall_i
);

  logic             out_valid_q;
  logic             skid_valid_q;
  kst_pkg::result_t out_data_q;
  kst_pkg::result_t skid_data_q;
  logic             accept;
  logic             out_free;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (accept) begin
        out_data_q <= in_data_i;
      end
    end else if (accept) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled while output was free");

  a_skid_drain_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (!skid_valid_q && out_data_q == $past(skid_data_q)))
    else $error("skid entry not moved to output in order");

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_scanner_with_key_tone.sv =====
// Top level of the 4x4 matrix keypad scanner with per-key buzzer tone.
// Results are registered in the output stage; the phase/counter update is one
// registered pass. Throughput: one tick beat per cycle while in_stall_o is low.
// A two-entry output stage keeps taking beats while one result waits on out_stall_i.
// Reset (rst_ni low, async): waiting for press, all counters and held key zero,
// registers back to debounce 25, settle 2, gap 20, tone enabled; output stage empty.
`default_nettype none

module keypad_scanner_with_key_tone (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Tick beat channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [kst_pkg::RowW-1:0]      row_levels_i,
  // Result beat channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [kst_pkg::ColW-1:0]      column_drive_o,
  output logic                               buzzer_level_o,
  output logic                               key_strobe_o,
  output logic      [kst_pkg::KeyW-1:0]      key_code_o,
  output logic                               busy_res_o,
  // Configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [kst_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [kst_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  typedef enum logic [2:0] {
    PhWait       = 3'd0,
    PhDebPress   = 3'd1,
    PhScan       = 3'd2,
    PhRelease    = 3'd3,
    PhDebRelease = 3'd4,
    PhTone       = 3'd5,
    PhGap        = 3'd6
  } phase_e;

  // Configuration registers
  logic [kst_pkg::TimerW-1:0]  debounce_q;
  logic [kst_pkg::SettleW-1:0] settle_q;
  logic [kst_pkg::TimerW-1:0]  gap_q;
  logic                        tone_en_q;

  // Scanner state
  phase_e                     phase_q, phase_d;
  logic [kst_pkg::TimerW-1:0] timer_q, timer_d;
  logic [1:0]                 col_q, col_d;
  logic [kst_pkg::KeyW-1:0]   key_q, key_d;
  logic [kst_pkg::RepW-1:0]   rep_q, rep_d;
  logic [kst_pkg::HalfW-1:0]  half_q, half_d;
  logic                       wave_q, wave_d;

  logic                       in_acc;
  logic                       skid_stall;
  kst_pkg::result_t           res;
  kst_pkg::result_t           res_out;

  logic [kst_pkg::TimerW-1:0] timer_dec;
  logic [kst_pkg::HalfW-1:0]  half_dec;
  logic [kst_pkg::RepW-1:0]   rep_dec;
  logic [kst_pkg::HalfW-1:0]  half_load;
  logic [kst_pkg::TimerW-1:0] settle_load;
  logic                       row_hit;
  logic [1:0]                 row_idx;

  assign in_acc     = in_valid_i && !skid_stall;
  assign in_stall_o = skid_stall;

  assign timer_dec   = (timer_q != '0) ? timer_q - 1'b1 : '0;
  assign half_dec    = (half_q != '0) ? half_q - 1'b1 : '0;
  assign rep_dec     = (rep_q != '0) ? rep_q - 1'b1 : '0;
  assign half_load   = {1'b0, key_q} + 5'd1;
  assign settle_load = {{(kst_pkg::TimerW - kst_pkg::SettleW){1'b0}}, settle_q};

  // Lowest-numbered high row wins.
  always_comb begin
    row_hit = |row_levels_i;
    if (row_levels_i[0]) begin
      row_idx = 2'd0;
    end else if (row_levels_i[1]) begin
      row_idx = 2'd1;
    end else if (row_levels_i[2]) begin
      row_idx = 2'd2;
    end else begin
      row_idx = 2'd3;
    end
  end

  // Result of this tick: drive, buzzer and busy come from the state at tick start.
  always_comb begin
    res.column_drive = 4'hF;
    res.buzzer_level = 1'b0;
    res.key_strobe   = 1'b0;
    res.busy_res     = (phase_q != PhWait);
    if (phase_q == PhScan) begin
      res.column_drive = 4'b0001 << col_q;
    end
    if (phase_q == PhTone) begin
      res.buzzer_level = wave_q;
    end

    phase_d = phase_q;
    timer_d = timer_q;
    col_d   = col_q;
    key_d   = key_q;
    rep_d   = rep_q;
    half_d  = half_q;
    wave_d  = wave_q;

    case (phase_q)
      PhDebPress: begin
        if (timer_q != '0) begin
          timer_d = timer_dec;
        end else begin
          phase_d = PhScan;
          col_d   = 2'd0;
          timer_d = settle_load;
        end
      end
      PhScan: begin
        if (timer_q != '0) begin
          timer_d = timer_dec;
        end else if (row_hit) begin
          key_d   = {row_idx, col_q};
          phase_d = PhRelease;
        end else begin
          // Advance to the next column, wrapping after the last.
          col_d   = col_q + 2'd1;
          timer_d = settle_load;
        end
      end
      PhRelease: begin
        if (!row_hit) begin
          phase_d = PhDebRelease;
          timer_d = debounce_q;
        end
      end
      PhDebRelease: begin
        if (timer_q != '0) begin
          timer_d = timer_dec;
        end else begin
          res.key_strobe = 1'b1;
          if (tone_en_q) begin
            phase_d = PhTone;
            rep_d   = kst_pkg::repeat_count(key_q);
            half_d  = half_load;
            wave_d  = 1'b1;
          end else begin
            phase_d = PhGap;
            timer_d = gap_q;
          end
        end
      end
      PhTone: begin
        half_d = half_dec;
        if (half_dec == '0) begin
          if (wave_q) begin
            wave_d = 1'b0;
            half_d = half_load;
          end else begin
            rep_d = rep_dec;
            if (rep_dec == '0) begin
              phase_d = PhGap;
              timer_d = gap_q;
              wave_d  = 1'b0;
            end else begin
              wave_d = 1'b1;
              half_d = half_load;
            end
          end
        end
      end
      PhGap: begin
        if (timer_q != '0) begin
          timer_d = timer_dec;
        end else begin
          phase_d = PhWait;
        end
      end
      default: begin
        // Idle, and any stray phase code: wait for a press.
        phase_d = PhWait;
        if (row_hit) begin
          phase_d = PhDebPress;
          timer_d = debounce_q;
        end
      end
    endcase

    // The key code already shows a key decoded on this tick.
    res.key_code = key_d;
  end

  // Scanner state advances only on an accepted tick beat; config follows cfg_we_i.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= 8'd25;
      settle_q   <= 4'd2;
      gap_q      <= 8'd20;
      tone_en_q  <= 1'b1;
      phase_q    <= PhWait;
      timer_q    <= '0;
      col_q      <= '0;
      key_q      <= '0;
      rep_q      <= '0;
      half_q     <= '0;
      wave_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kst_pkg::CfgDebounce: debounce_q <= cfg_wdata_i;
          kst_pkg::CfgSettle:   settle_q   <= cfg_wdata_i[kst_pkg::SettleW-1:0];
          kst_pkg::CfgGap:      gap_q      <= cfg_wdata_i;
          kst_pkg::CfgToneEn:   tone_en_q  <= cfg_wdata_i[0];
          default:              tone_en_q  <= tone_en_q;
        endcase
      end
      if (in_acc) begin
        phase_q <= phase_d;
        timer_q <= timer_d;
        col_q   <= col_d;
        key_q   <= key_d;
        rep_q   <= rep_d;
        half_q  <= half_d;
        wave_q  <= wave_d;
      end
    end
  end

  // Result beats leave through the two-entry output stage.
  kst_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (res),
    .in_stall_o  (skid_stall),
    .out_valid_o (out_valid_o),
    .out_data_o  (res_out),
    .out_stall_i (out_stall_i)
  );

  assign column_drive_o = res_out.column_drive;
  assign buzzer_level_o = res_out.buzzer_level;
  assign key_strobe_o   = res_out.key_strobe;
  assign key_code_o     = res_out.key_code;
  assign busy_res_o     = res_out.busy_res;

  a_phase_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(phase_q))
    else $error("phase moved without an accepted tick");

  a_tone_counters_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhTone) |-> (half_q != '0 && rep_q != '0))
    else $error("tone phase with an exhausted counter");

  a_report_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PhDebRelease && timer_q == '0)
      |=> (phase_q == PhTone || phase_q == PhGap))
    else $error("key report did not lead to tone or gap");

endmodule

`default_nettype wire
